[design/sobth_pkg.sv]
// ----------------------------------------------------------------------------
// sobth_pkg
// shared types and constants of the sobel edge threshold block
// ----------------------------------------------------------------------------
package sobth_pkg;

  localparam int PIX_W     = 8;   // gray pixel
  localparam int CFG_W     = 11;  // width of each configuration register
  localparam int COORD_W   = 10;  // centre coordinate fields
  localparam int GRAD_W    = 11;  // signed sobel gradient
  localparam int SQ_W      = 21;  // one squared gradient
  localparam int MAG_W     = 22;  // gx^2 + gy^2
  localparam int THR_SQ_W  = 23;  // (threshold + 1)^2
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int OUT_DW    = 24;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [CFG_W-1:0] THRESH_RST = 11'd100;
  localparam logic [CFG_W-1:0] MIN_DIM    = 11'd3;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]    width;
    logic [CFG_W-1:0]    height;
    logic [THR_SQ_W-1:0] thr_sq;
  } cfg_t;

  // per item tag that rides along the pipeline
  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } tag_t;

endpackage

[design/sobel_edge_threshold.sv]
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// 3x3 sobel edge detector with squared magnitude threshold on a gray stream
// ----------------------------------------------------------------------------
// path to the master side: stage 1, window, magnitude and output registers
// throughput: one pixel per cycle, set by one read and one write per line
//   buffer per cycle and the four stage pipeline, which all advance together
//   on one enable; a result held by the sink stalls the pixel input
// reset: counters and valids cleared, registers back to 640 x 480 and
//   threshold 100; line buffer contents are undefined until a row is written
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel stream in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [sobth_pkg::PIX_W-1:0]   s_axis_tdata_i,   // [7:0] gray_pixel
  // edge result stream out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] edge_res, [10:1] centre_column, [20:11] centre_row, [23:21] zero
  output logic [sobth_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,   // frame_last
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sobth_pkg::APB_AW-1:0]  paddr,
  input  logic [sobth_pkg::APB_DW-1:0]  pwdata,
  output logic [sobth_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import sobth_pkg::*;

  // counter and compare widths
  localparam int CB  = $clog2(MAX_WIDTH);         // column counter / line address
  localparam int RB  = $clog2(MAX_HEIGHT);        // row counter
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = (WB > CFG_W) ? WB : CFG_W; // width compare domain
  localparam int HW  = (HB > CFG_W) ? HB : CFG_W; // height compare domain
  localparam int CXW = (CB > COORD_W) ? CB : COORD_W;
  localparam int RXW = (RB > COORD_W) ? RB : COORD_W;

  cfg_t cfg;

  // whole pipeline moves when the output register is free or being drained
  logic adv, accept;

  // raster counters
  logic [CB-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  logic [CW-1:0] w_cfg, w_eff, col_p1;
  logic [HW-1:0] h_cfg, h_eff, row_p1;
  logic          row_end, frame_end;
  logic [CXW-1:0] col_x;
  logic [RXW-1:0] row_x;
  tag_t           tag_in;

  // stage 1: pixel waiting for its line buffer reads
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CB-1:0]    s1_addr_q;
  tag_t             s1_tag_q;
  logic [PIX_W-1:0] top_rd, mid_rd;
  logic             s1_fire;

  // later stages
  logic                     s2_valid;
  logic signed [GRAD_W-1:0] s2_gx, s2_gy;
  tag_t                     s2_tag;
  logic                     s3_valid, s3_edge;
  tag_t                     s3_tag;

  // output register
  logic       out_valid_q;
  logic       out_edge_q;
  tag_t       out_tag_q;

  sobth_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv             = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i & adv;

  // effective frame size, saturated into the supported range
  always_comb begin
    w_cfg = CW'(cfg.width);
    h_cfg = HW'(cfg.height);
    if (w_cfg < CW'(MIN_DIM)) begin
      w_eff = CW'(MIN_DIM);
    end else if (w_cfg > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg < HW'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (h_cfg > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
  end

  assign col_p1    = CW'(col_q) + CW'(1);
  assign row_p1    = HW'(row_q) + HW'(1);
  assign row_end   = col_p1 >= w_eff;
  assign frame_end = row_end & (row_p1 >= h_eff);

  // centre is one up and one left of the incoming pixel
  assign col_x       = CXW'(col_q) - CXW'(1);
  assign row_x       = RXW'(row_q) - RXW'(1);
  assign tag_in.emit = (CXW'(col_q) >= CXW'(2)) & (RXW'(row_q) >= RXW'(2));
  assign tag_in.col  = col_x[COORD_W-1:0];
  assign tag_in.row  = row_x[COORD_W-1:0];
  assign tag_in.last = frame_end;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_p1[RB-1:0];
      end else begin
        col_d = col_p1[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (adv) begin
        s1_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata_i;
      s1_addr_q <= col_q;
      s1_tag_q  <= tag_in;
    end
  end

  // read at accept, write back when the item leaves stage 1; the same
  // address comes back only a full row later, so there is no hazard
  assign s1_fire = adv & s1_valid_q;

  sobth_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (CB)
  ) u_upper (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (top_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (mid_rd)
  );

  sobth_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (CB)
  ) u_middle (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (s1_pix_q)
  );

  sobth_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_valid_q),
    .top_i   (top_rd),
    .mid_i   (mid_rd),
    .bot_i   (s1_pix_q),
    .tag_i   (s1_tag_q),
    .valid_o (s2_valid),
    .gx_o    (s2_gx),
    .gy_o    (s2_gy),
    .tag_o   (s2_tag)
  );

  sobth_magnitude u_mag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s2_valid),
    .gx_i     (s2_gx),
    .gy_i     (s2_gy),
    .tag_i    (s2_tag),
    .thr_sq_i (cfg.thr_sq),
    .valid_o  (s3_valid),
    .edge_o   (s3_edge),
    .tag_o    (s3_tag)
  );

  // only window centres away from the border produce a beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid & s3_tag.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid && s3_tag.emit) begin
      out_edge_q <= s3_edge;
      out_tag_q  <= s3_tag;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_tag_q.row, out_tag_q.col, out_edge_q};
  assign m_axis_tlast_o  = out_tag_q.last;

endmodule

[design/sobth_regs.sv]
// ----------------------------------------------------------------------------
// sobth_regs
// apb register file: image size and edge threshold, (threshold + 1) squared
// ----------------------------------------------------------------------------
module sobth_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sobth_pkg::APB_AW-1:0] paddr,
  input  logic [sobth_pkg::APB_DW-1:0] pwdata,
  output logic [sobth_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  output sobth_pkg::cfg_t              cfg_o
);
  import sobth_pkg::*;

  // threshold + 1 at reset, already widened to the square's width
  localparam logic [THR_SQ_W-1:0] THR_P1_RST = THR_SQ_W'(THRESH_RST) + THR_SQ_W'(1);

  logic [CFG_W-1:0]    width_q, height_q, thresh_q;
  logic [THR_SQ_W-1:0] thr_sq_q;
  logic [CFG_W:0]      thr_p1;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign thr_p1 = {1'b0, thresh_q} + {{CFG_W{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
      thr_sq_q <= THR_P1_RST * THR_P1_RST;
    end else begin
      thr_sq_q <= THR_SQ_W'(thr_p1) * THR_SQ_W'(thr_p1);
      if (wr_en) begin
        case (idx)
          REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
          REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
          REG_THRESH: thresh_q <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_THRESH: prdata = APB_DW'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.thr_sq = thr_sq_q;

endmodule

[design/sobth_line_buffer.sv]
// ----------------------------------------------------------------------------
// sobth_line_buffer
// one line of pixels, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sobth_line_buffer #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [sobth_pkg::PIX_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [sobth_pkg::PIX_W-1:0] wr_data_i
);
  import sobth_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/sobth_window.sv]
// ----------------------------------------------------------------------------
// sobth_window
// two column 3x3 window history and sobel gradient register
// ----------------------------------------------------------------------------
module sobth_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic [sobth_pkg::PIX_W-1:0]         top_i,
  input  logic [sobth_pkg::PIX_W-1:0]         mid_i,
  input  logic [sobth_pkg::PIX_W-1:0]         bot_i,
  input  sobth_pkg::tag_t                     tag_i,
  output logic                                valid_o,
  output logic signed [sobth_pkg::GRAD_W-1:0] gx_o,
  output logic signed [sobth_pkg::GRAD_W-1:0] gy_o,
  output sobth_pkg::tag_t                     tag_o
);
  import sobth_pkg::*;

  // [0..2] column x-2 top/mid/bot, [3..5] column x-1
  logic [PIX_W-1:0]         win_q [6];
  logic                     valid_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q, gx_d, gy_d;
  tag_t                     tag_q;
  logic [PIX_W+1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic                     fire;

  assign fire = adv_i & valid_i;

  always_comb begin
    gx_pos = {2'b0, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b0, bot_i};
    gx_neg = {2'b0, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b0, top_i};
    gy_pos = {2'b0, top_i} + {1'b0, mid_i, 1'b0} + {2'b0, bot_i};
    gy_neg = {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, win_q[2]};
    gx_d   = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
    gy_d   = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (adv_i) begin
        valid_q <= valid_i;
      end
      if (fire) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_i;
        win_q[4] <= mid_i;
        win_q[5] <= bot_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign gx_o    = gx_q;
  assign gy_o    = gy_q;
  assign tag_o   = tag_q;

endmodule

[design/sobth_magnitude.sv]
// ----------------------------------------------------------------------------
// sobth_magnitude
// squared gradient stage and threshold compare
// ----------------------------------------------------------------------------
module sobth_magnitude (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic signed [sobth_pkg::GRAD_W-1:0] gx_i,
  input  logic signed [sobth_pkg::GRAD_W-1:0] gy_i,
  input  sobth_pkg::tag_t                     tag_i,
  input  logic [sobth_pkg::THR_SQ_W-1:0]      thr_sq_i,
  output logic                                valid_o,
  output logic                                edge_o,
  output sobth_pkg::tag_t                     tag_o
);
  import sobth_pkg::*;

  logic signed [2*GRAD_W-1:0] px, py;
  logic [SQ_W-1:0]            sqx_q, sqy_q;
  logic [MAG_W-1:0]           mag;
  logic                       valid_q;
  tag_t                       tag_q;

  assign px = gx_i * gx_i;
  assign py = gy_i * gy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      sqx_q <= px[SQ_W-1:0];
      sqy_q <= py[SQ_W-1:0];
      tag_q <= tag_i;
    end
  end

  assign mag     = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign edge_o  = {1'b0, mag} >= thr_sq_i;
  assign valid_o = valid_q;
  assign tag_o   = tag_q;

endmodule
